// ===== src/sat_pkg.sv =====
// Package for the summed-area table block: sizes, beat and operation types,
// register indexes and the table address function. No dependencies.
package sat_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 256;
  localparam int VALUE_WIDTH = 16;

  localparam int SUM_W     = 32;
  localparam int COORD_W   = 8;
  localparam int CNT_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [15:0]        value;
    logic        [COORD_W-1:0] top_row;
    logic        [COORD_W-1:0] left_col;
    logic        [COORD_W-1:0] bottom_row;
    logic        [COORD_W-1:0] right_col;
  } sat_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] rect_sum;
    logic                    query_error;
  } sat_out_t;

  // For a load, addr[0] is the entry written and addr[1] the entry above.
  // For a query, addr[0..3] are the four corners in sum order + - - +.
  typedef struct packed {
    logic                         is_query;
    logic                         err;
    logic [SUM_W-1:0]             rsum;
    logic [3:0][ADDR_W-1:0]       addr;
    logic [3:0]                   mask;
  } sat_op_t;

  function automatic logic [ADDR_W-1:0] sat_addr(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    return a;
  endfunction

endpackage

// ===== src/summed_area_table_query_top.sv =====
// Top level of the summed-area table block: front end, operation queue and
// back end. Depends on sat_pkg, sat_front, sat_queue and sat_back.
//
//   Channel   Ports                         Beat
//   config    cfg_valid/ready/index/data    one register write
//   input     in_valid/ready/data           one load or query
//   result    out_valid/ready/data          one query answer
//
// In the back end a load reads the entry above, then writes its own entry.
// A query makes four reads through the single table read port; a rejected
// query goes straight to its result. A two-entry queue lets loads and queries
// be taken while the back end works or a result waits. Reset is synchronous;
// the table memory is not cleared; loads rewrite only the configured area.
module summed_area_table_query_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sat_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sat_pkg::sat_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sat_pkg::sat_out_t             out_data
);
  import sat_pkg::*;

  logic    push, q_full, pop, head_valid;
  sat_op_t push_op, head_op;

  sat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_op   (push_op),
    .q_full    (q_full)
  );

  sat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  sat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== src/sat_front.sv =====
// Front end of the summed-area table block: configuration registers, load
// position tracking, running row sum and query checks. Uses sat_pkg.
module sat_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sat_pkg::CNT_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sat_pkg::sat_in_t                 in_data,
  output logic                             push,
  output sat_pkg::sat_op_t                 push_op,
  input  logic                             q_full
);
  import sat_pkg::*;

  logic [CNT_W-1:0]   row_count_r, col_count_r;
  logic [COORD_W-1:0] load_row_r, load_col_r;
  logic [SUM_W-1:0]   row_sum_r;
  logic               complete_r;

  logic [CNT_W-1:0]   rows, cols;
  logic               restart, last_col, last_row, q_err;
  logic [COORD_W-1:0] r, c, t, l, b, rc;
  logic [SUM_W-1:0]   v, rsum;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  always_comb begin
    if (row_count_r == '0) begin
      rows = CNT_W'(1);
    end else if (row_count_r > CNT_W'(MAX_ROWS)) begin
      rows = CNT_W'(MAX_ROWS);
    end else begin
      rows = row_count_r;
    end
    if (col_count_r == '0) begin
      cols = CNT_W'(1);
    end else if (col_count_r > CNT_W'(MAX_COLS)) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = col_count_r;
    end
  end

  always_comb begin
    restart  = complete_r || ({1'b0, load_row_r} >= rows) || ({1'b0, load_col_r} >= cols);
    r        = restart ? '0 : load_row_r;
    c        = restart ? '0 : load_col_r;
    v        = {{(SUM_W-VALUE_WIDTH){in_data.value[VALUE_WIDTH-1]}},
                in_data.value[VALUE_WIDTH-1:0]};
    rsum     = (c == '0) ? v : row_sum_r + v;
    last_col = !(({1'b0, c} + CNT_W'(1)) < cols);
    last_row = !(({1'b0, r} + CNT_W'(1)) < rows);

    t  = in_data.top_row;
    l  = in_data.left_col;
    b  = in_data.bottom_row;
    rc = in_data.right_col;
    q_err = !complete_r || (t > b) || (l > rc) ||
            ({1'b0, b} >= rows) || ({1'b0, rc} >= cols);

    push_op = '0;
    if (in_data.cmd == CMD_QUERY) begin
      push_op.is_query = 1'b1;
      push_op.err      = q_err;
      push_op.addr[0]  = sat_addr(b, rc);
      push_op.addr[1]  = sat_addr(t - COORD_W'(1), rc);
      push_op.addr[2]  = sat_addr(b, l - COORD_W'(1));
      push_op.addr[3]  = sat_addr(t - COORD_W'(1), l - COORD_W'(1));
      push_op.mask     = {(t != '0) && (l != '0), l != '0, t != '0, 1'b1};
    end else begin
      push_op.rsum    = rsum;
      push_op.addr[0] = sat_addr(r, c);
      push_op.addr[1] = sat_addr(r - COORD_W'(1), c);
      push_op.mask    = {2'b00, r != '0, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_W'(256);
      col_count_r <= CNT_W'(256);
      load_row_r  <= '0;
      load_col_r  <= '0;
      row_sum_r   <= '0;
      complete_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT)) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_count_r <= cfg_data;
      end else begin
        col_count_r <= cfg_data;
      end
      load_row_r <= '0;
      load_col_r <= '0;
      row_sum_r  <= '0;
      complete_r <= 1'b0;
    end else if (push && in_data.cmd == CMD_LOAD) begin
      row_sum_r  <= rsum;
      complete_r <= last_col && last_row;
      load_col_r <= last_col ? '0 : c + COORD_W'(1);
      if (last_col) begin
        load_row_r <= last_row ? '0 : r + COORD_W'(1);
      end else begin
        load_row_r <= r;
      end
    end
  end

endmodule

// ===== src/sat_queue.sv =====
// Short in-order queue of classified operations between front and back end.
// Uses sat_pkg for the operation type and depth.
module sat_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sat_pkg::sat_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output sat_pkg::sat_op_t head_op
);
  import sat_pkg::*;

  sat_op_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    count_r;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== src/sat_back.sv =====
// Back end of the summed-area table block: the table memory, the load and
// query sequencer and the result register. Uses sat_pkg.
module sat_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  sat_pkg::sat_op_t head_op,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output sat_pkg::sat_out_t out_data
);
  import sat_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD_WR, ST_QRD, ST_FIN, ST_DONE
  } state_t;

  logic [SUM_W-1:0]  sum_table [MEM_DEPTH];
  logic [SUM_W-1:0]  rdata_r;

  state_t            state_r;
  sat_op_t           cur_r;
  logic [1:0]        cnt_r;
  logic [SUM_W-1:0]  acc_r;
  logic              err_r;
  logic              out_valid_r;
  sat_out_t          out_data_r;

  logic              re, we;
  logic [ADDR_W-1:0] raddr;
  logic [1:0]        k;
  logic [SUM_W-1:0]  term, acc_nxt;

  assign pop       = (state_r == ST_IDLE) && head_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    re    = 1'b0;
    raddr = cur_r.addr[cnt_r];
    if (pop) begin
      re    = 1'b1;
      raddr = head_op.is_query ? head_op.addr[0] : head_op.addr[1];
    end else if (state_r == ST_QRD) begin
      re = 1'b1;
    end
    we = (state_r == ST_LOAD_WR);

    k       = (state_r == ST_FIN) ? 2'd3 : cnt_r - 2'd1;
    term    = cur_r.mask[k] ? rdata_r : '0;
    acc_nxt = (k == 2'd1 || k == 2'd2) ? acc_r - term : acc_r + term;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      sum_table[cur_r.addr[0]] <= (cur_r.mask[1] ? rdata_r : '0) + cur_r.rsum;
    end
    if (re) begin
      rdata_r <= sum_table[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (head_valid) begin
            cur_r <= head_op;
            acc_r <= '0;
            err_r <= head_op.err;
            cnt_r <= 2'd1;
            if (!head_op.is_query) begin
              state_r <= ST_LOAD_WR;
            end else if (head_op.err) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_QRD;
            end
          end
        end
        ST_LOAD_WR: begin
          state_r <= ST_IDLE;
        end
        ST_QRD: begin
          acc_r <= acc_nxt;
          if (cnt_r == 2'd3) begin
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 2'd1;
          end
        end
        ST_FIN: begin
          acc_r   <= acc_nxt;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.rect_sum    <= acc_r;
            out_data_r.query_error <= err_r;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
